// ----- rtl/core/bec_pkg.sv -----
// ----------------------------------------------------------------------------
// bec_pkg: shared types and constants for the button event counter
// Button count, request codes, register indexes, entry layout, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bec_pkg;

   localparam int NUM_BUTTONS     = 20;
   localparam int SAMPLED_BUTTONS = NUM_BUTTONS - 4;
   localparam int BTN_IDX_W       = $clog2(NUM_BUTTONS);
   localparam int BTN_CNT_W       = $clog2(NUM_BUTTONS + 1);
   localparam int IDX_PORT_W      = 5;
   localparam int TIME_W          = 32;
   localparam int COUNT_W         = 8;
   localparam int CSR_IDX_W       = 1;

   localparam logic [2:0] REQ_MOVE     = 3'd0;
   localparam logic [2:0] REQ_NOTIFY   = 3'd1;
   localparam logic [2:0] REQ_STATE    = 3'd2;
   localparam logic [2:0] REQ_DOWN     = 3'd3;
   localparam logic [2:0] REQ_UP       = 3'd4;
   localparam logic [2:0] REQ_HOLD     = 3'd5;
   localparam logic [2:0] REQ_OVERRIDE = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_READY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDINAL_MODE = 1'd1;

   typedef struct packed {
      logic               ignored;
      logic               pressed;
      logic               prev_sample;
      logic [TIME_W-1:0]  hold_time;
      logic [COUNT_W-1:0] down_count;
      logic [COUNT_W-1:0] up_count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SWEEP,
      ST_QUERY,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/button_event_counter.sv -----
// ----------------------------------------------------------------------------
// button_event_counter: press, release and hold tracking for a set of buttons
// Accept to rsp_valid: sample PREP, SWEEP, DONE; dropped or first sample PREP, DONE;
// query QUERY, DONE; override, gated query, unused code DONE. A sample walks the RAM
// one entry per cycle (read and write-back overlap); a new request waits until the
// response is issued. Synchronous reset clears control state, the time base and all
// entry valid bits; an entry not written since reset reads as zero. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module button_event_counter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [2:0]                        req_type,
   input  wire logic [bec_pkg::IDX_PORT_W-1:0]    req_button_index,
   input  wire logic [31:0]                       req_raw_buttons,
   input  wire logic                              req_pov_centered,
   input  wire logic [bec_pkg::TIME_W-1:0]        req_now_time,
   input  wire logic                              req_set_pressed,
   input  wire logic [bec_pkg::TIME_W-1:0]        req_set_hold_time,
   input  wire logic [bec_pkg::COUNT_W-1:0]       req_set_down_count,
   input  wire logic [bec_pkg::COUNT_W-1:0]       req_set_up_count,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [31:0]                            rsp_read_value,
   input  wire logic                              csr_we,
   input  wire logic [bec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic                              csr_wdata
);

   import bec_pkg::*;

   state_type              state_ff, state_in;
   logic [BTN_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   wb_vld_ff, wb_vld_in;
   logic [BTN_IDX_W-1:0]   wb_idx_ff, wb_idx_in;
   logic [TIME_W-1:0]      span_ff, span_in;
   logic [NUM_BUTTONS-1:0] mask_ff, mask_in;
   logic [TIME_W-1:0]      last_time_ff, last_time_in;
   logic                   time_valid_ff, time_valid_in;
   logic [31:0]            result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_read_value_ff, rsp_read_value_in;
   logic [NUM_BUTTONS-1:0] vld_ff, vld_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   device_ready_ff;
   logic                   ordinal_mode_ff;

   logic [2:0]             type_ff;
   logic [BTN_IDX_W-1:0]   idx_ff;
   logic [31:0]            raw_ff;
   logic                   pov_ff;
   logic [TIME_W-1:0]      now_ff;

   logic                   ram_wr_en;
   logic [BTN_IDX_W-1:0]   ram_wr_addr;
   entry_type              ram_wr_data;
   logic                   ram_rd_en;
   logic [BTN_IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_rd_data;

   entry_type              rd_entry;
   entry_type              wb_entry;
   entry_type              q_entry;
   entry_type              ovr_entry;
   logic [31:0]            q_result;
   logic                   lvl;
   logic [TIME_W-1:0]      base;
   logic [TIME_W-1:0]      span_calc;
   logic [4:0]             raw_m1;
   logic                   ord_hit;
   logic [31:0]            mask32;
   logic                   accept;
   logic                   in_range;
   logic [BTN_IDX_W-1:0]   req_addr;
   logic [BTN_IDX_W-1:0]   cnt_addr;

   bec_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BUTTONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept   = req_valid & req_ready;
   assign in_range = {1'b0, req_button_index} < (IDX_PORT_W+1)'(NUM_BUTTONS);
   assign req_addr = req_button_index[BTN_IDX_W-1:0];
   assign cnt_addr = cnt_ff[BTN_IDX_W-1:0];

   assign rd_entry = rd_vld_ff ? entry_type'(ram_rd_data) : '0;

   // interval with the wrap rule applied to the old timestamp
   always_comb begin
      base      = (now_ff < last_time_ff) ? (last_time_ff - now_ff) : last_time_ff;
      span_calc = now_ff - base;
   end

   always_comb begin
      raw_m1  = raw_ff[4:0] - 5'd1;
      ord_hit = pov_ff && (raw_ff != 32'd0) && (raw_ff <= 32'd32);
      if (type_ff == REQ_NOTIFY) begin
         mask32 = '0;
      end else if (ordinal_mode_ff) begin
         mask32 = ord_hit ? (32'd1 << raw_m1) : 32'd0;
      end else begin
         mask32 = raw_ff;
      end
   end

   // sweep update of one entry
   always_comb begin
      lvl      = mask_ff[wb_idx_ff];
      wb_entry = rd_entry;
      if (rd_entry.prev_sample == lvl) begin
         if (lvl) begin
            wb_entry.hold_time = rd_entry.hold_time + span_ff;
         end
      end else begin
         if (lvl) begin
            wb_entry.down_count = rd_entry.down_count + COUNT_W'(1);
            wb_entry.pressed    = 1'b1;
         end else begin
            wb_entry.up_count = rd_entry.up_count + COUNT_W'(rd_entry.pressed);
            wb_entry.pressed  = 1'b0;
         end
         wb_entry.prev_sample = lvl;
      end
   end

   always_comb begin
      q_entry  = rd_entry;
      q_result = '0;
      case (type_ff)
         REQ_STATE: begin
            q_result = 32'(rd_entry.pressed);
         end
         REQ_DOWN: begin
            q_result           = 32'(rd_entry.down_count);
            q_entry.down_count = '0;
         end
         REQ_UP: begin
            q_result         = 32'(rd_entry.up_count);
            q_entry.up_count = '0;
         end
         REQ_HOLD: begin
            q_result          = rd_entry.hold_time;
            q_entry.hold_time = '0;
         end
         default: begin
            q_result = '0;
         end
      endcase
   end

   always_comb begin
      ovr_entry             = '0;
      ovr_entry.ignored     = 1'b1;
      ovr_entry.pressed     = req_set_pressed;
      ovr_entry.hold_time   = req_set_hold_time;
      ovr_entry.down_count  = req_set_down_count;
      ovr_entry.up_count    = req_set_up_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      wb_vld_in         = 1'b0;
      wb_idx_in         = wb_idx_ff;
      span_in           = span_ff;
      mask_in           = mask_ff;
      last_time_in      = last_time_ff;
      time_valid_in     = time_valid_ff;
      result_in         = result_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_read_value_in = rsp_read_value_ff;
      vld_in            = vld_ff;
      rd_vld_in         = rd_vld_ff;
      req_ready         = 1'b0;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = cnt_addr;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = wb_idx_ff;
      ram_wr_data       = wb_entry;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               result_in = '0;
               case (req_type) inside
                  REQ_MOVE, REQ_NOTIFY: begin
                     state_in = ST_PREP;
                  end
                  [REQ_STATE:REQ_HOLD]: begin
                     if (device_ready_ff && in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_addr;
                        rd_vld_in   = vld_ff[req_addr];
                        state_in    = ST_QUERY;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  REQ_OVERRIDE: begin
                     if (in_range) begin
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = req_addr;
                        ram_wr_data      = ovr_entry;
                        vld_in[req_addr] = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PREP: begin
            if (!device_ready_ff) begin
               state_in = ST_DONE;
            end else if (!time_valid_ff) begin
               last_time_in  = now_ff;
               time_valid_in = 1'b1;
               state_in      = ST_DONE;
            end else begin
               span_in      = span_calc;
               mask_in      = NUM_BUTTONS'(mask32[SAMPLED_BUTTONS-1:0]);
               last_time_in = now_ff;
               cnt_in       = '0;
               state_in     = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (cnt_ff < BTN_CNT_W'(NUM_BUTTONS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_addr;
               rd_vld_in   = vld_ff[cnt_addr];
               wb_vld_in   = 1'b1;
               wb_idx_in   = cnt_addr;
               cnt_in      = cnt_ff + BTN_CNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_QUERY: begin
            result_in = q_result;
            if (type_ff != REQ_STATE) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = idx_ff;
               ram_wr_data    = q_entry;
               vld_in[idx_ff] = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = result_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // write back the entry read on the previous sweep cycle
      if (wb_vld_ff && !rd_entry.ignored) begin
         ram_wr_en         = 1'b1;
         ram_wr_addr       = wb_idx_ff;
         ram_wr_data       = wb_entry;
         vld_in[wb_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff          <= '0;
         wb_vld_ff       <= 1'b0;
         last_time_ff    <= '0;
         time_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         vld_ff          <= '0;
         rd_vld_ff       <= 1'b0;
         device_ready_ff <= 1'b0;
         ordinal_mode_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         wb_vld_ff     <= wb_vld_in;
         last_time_ff  <= last_time_in;
         time_valid_ff <= time_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         vld_ff        <= vld_in;
         rd_vld_ff     <= rd_vld_in;
         if (csr_we && (csr_index == CSR_DEVICE_READY)) begin
            device_ready_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_ORDINAL_MODE)) begin
            ordinal_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      wb_idx_ff         <= wb_idx_in;
      span_ff           <= span_in;
      mask_ff           <= mask_in;
      result_ff         <= result_in;
      rsp_read_value_ff <= rsp_read_value_in;
      if (accept) begin
         type_ff <= req_type;
         idx_ff  <= req_addr;
         raw_ff  <= req_raw_buttons;
         pov_ff  <= req_pov_centered;
         now_ff  <= req_now_time;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bec_ram.sv -----
// ----------------------------------------------------------------------------
// bec_ram: generic single-port-write, single-port-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/bec_checker.sv -----
// ----------------------------------------------------------------------------
// bec_checker: port-level checks for the button event counter
// Output stall hold, busy after accept, clean state out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_read_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("rsp beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while previous beat still in work");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_reset_done_no_rsp: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp beat without request after reset");

endmodule

bind button_event_counter bec_checker u_bec_checker (.*);

`default_nettype wire
